FILE: hdl/tick_driven_soft_timer_bank_macros.svh
// Assertion macros shared by the checker of the soft timer bank.
`ifndef TICK_DRIVEN_SOFT_TIMER_BANK_MACROS_SVH
`define TICK_DRIVEN_SOFT_TIMER_BANK_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define STFB_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("soft timer bank assertion failed");

// Same check with a message of the caller's choice.
`define STFB_ASSERT_MSG(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

`endif

FILE: hdl/stfb_pkg.sv
// Types, codes and reset values shared by the soft timer bank modules.
`default_nettype none
package stfb_pkg;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 17;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_MS_PRESCALE     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MEMORY    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_MEMORY     = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC_RELOAD = 4'd3;

	// Reset values of the configuration registers.
	localparam logic [3:0]  MS_PRESCALE_RST     = 4'd10;
	localparam logic [16:0] SHORT_MEMORY_RST    = 17'd10;
	localparam logic [16:0] LONG_MEMORY_RST     = 17'd100000;
	localparam logic [5:0]  PERIODIC_RELOAD_RST = 6'd40;

	typedef enum logic [2:0] {
		FUNC_TICK          = 3'd0,
		FUNC_ARM_MS        = 3'd1,
		FUNC_ARM_SHORT     = 3'd2,
		FUNC_ARM_LONG      = 3'd3,
		FUNC_LOAD_DELAY    = 3'd4,
		FUNC_WRITE_MS_FLAG = 3'd5,
		FUNC_CLEAR_PERIOD  = 3'd6,
		FUNC_SET_PERIOD    = 3'd7
	} func_t;

	typedef struct packed {
		func_t       func;
		logic [15:0] ms_value;
		logic [30:0] delay_value;
		logic        flag_value;
	} item_t;

	typedef struct packed {
		logic        ms_done;
		logic        memory_expired;
		logic [30:0] delay_left;
		logic        periodic_flag;
	} result_t;

	typedef struct packed {
		logic [3:0]  ms_prescale;
		logic [16:0] short_memory_ticks;
		logic [16:0] long_memory_ticks;
		logic [5:0]  periodic_reload;
	} cfg_t;

	// Hand-off from the input stage to the timer update.
	typedef struct packed {
		logic  valid;
		item_t item;
	} slot_t;

endpackage
`default_nettype wire

FILE: hdl/tick_driven_soft_timer_bank.sv
// Top level of the tick driven soft timer bank.
//
// The bank keeps four software timers that advance on a 100 microsecond tick:
// a delay down-counter that stops at zero, a millisecond timeout behind a
// programmable prescaler with a done flag, a memory timeout armed with a short
// or a long preset with an expired flag, and a free-running period counter that
// sets a sticky flag each time it runs out. Every input item is either a tick
// (func zero) or a command, and every item returns exactly one result item that
// shows all three flags and the remaining delay as they stand after that item.
// Only ticks advance the counters; commands load, arm or write flags.
// Items move through two register stages: an input register, then the timer
// update and the result register. A result is offered once its item has passed
// through both registers, and one item is taken every cycle as long as the
// downstream side keeps taking results. The input side stalls only while both
// stages hold an item and the output is stalled. Configuration writes are
// always accepted and take effect from the next item; write them only while
// no item is in flight.
`default_nettype none
module tick_driven_soft_timer_bank (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Input item channel.
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [2:0]                       func,
	input  wire logic [15:0]                      ms_value,
	input  wire logic [30:0]                      delay_value,
	input  wire logic                             flag_value,
	// Result item channel.
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic                                  ms_done,
	output logic                                  memory_expired,
	output logic [30:0]                           delay_left,
	output logic                                  periodic_flag,
	// Configuration write channel.
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [stfb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [stfb_pkg::CFG_DATA_W-1:0]  cfg_data
);

	stfb_pkg::cfg_t    cfg;
	stfb_pkg::item_t   item_in;
	stfb_pkg::slot_t   slot;
	stfb_pkg::result_t result_next;
	stfb_pkg::result_t result_out;
	logic              load;
	logic              advance;

	// The item in the input register moves on whenever the result register is
	// empty or its result is being taken in this cycle.
	assign advance  = slot.valid && (!out_valid || !out_stall);
	assign in_stall = slot.valid && out_valid && out_stall;
	assign load     = in_valid && !in_stall;

	// The register file can always take a write.
	assign cfg_ready = 1'b1;

	assign item_in.func        = stfb_pkg::func_t'(func);
	assign item_in.ms_value    = ms_value;
	assign item_in.delay_value = delay_value;
	assign item_in.flag_value  = flag_value;

	stfb_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	stfb_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.advance (advance),
		.item_in (item_in),
		.slot    (slot)
	);

	// The timer state commits together with the result register, so the state
	// always matches the last item that reached the output.
	stfb_timers u_timers (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (slot.item),
		.cfg     (cfg),
		.result  (result_next)
	);

	stfb_out_stage u_out_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.out_stall  (out_stall),
		.result_in  (result_next),
		.out_valid  (out_valid),
		.result_out (result_out)
	);

	assign ms_done        = result_out.ms_done;
	assign memory_expired = result_out.memory_expired;
	assign delay_left     = result_out.delay_left;
	assign periodic_flag  = result_out.periodic_flag;

endmodule
`default_nettype wire

FILE: hdl/stfb_cfg_regs.sv
// Configuration registers of the soft timer bank.
`default_nettype none
module stfb_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [stfb_pkg::CFG_IDX_W-1:0]   wr_index,
	input  wire logic [stfb_pkg::CFG_DATA_W-1:0]  wr_data,
	output stfb_pkg::cfg_t                        cfg
);

	stfb_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ms_prescale        <= stfb_pkg::MS_PRESCALE_RST;
			cfg_q.short_memory_ticks <= stfb_pkg::SHORT_MEMORY_RST;
			cfg_q.long_memory_ticks  <= stfb_pkg::LONG_MEMORY_RST;
			cfg_q.periodic_reload    <= stfb_pkg::PERIODIC_RELOAD_RST;
		end else if (wr_en) begin
			case (wr_index)
				stfb_pkg::CFG_MS_PRESCALE:     cfg_q.ms_prescale        <= wr_data[3:0];
				stfb_pkg::CFG_SHORT_MEMORY:    cfg_q.short_memory_ticks <= wr_data[16:0];
				stfb_pkg::CFG_LONG_MEMORY:     cfg_q.long_memory_ticks  <= wr_data[16:0];
				stfb_pkg::CFG_PERIODIC_RELOAD: cfg_q.periodic_reload    <= wr_data[5:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

FILE: hdl/stfb_in_stage.sv
// Input register stage of the soft timer bank.
`default_nettype none
module stfb_in_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           load,
	input  wire logic           advance,
	input  stfb_pkg::item_t     item_in,
	output stfb_pkg::slot_t     slot
);

	logic            valid_s1;
	stfb_pkg::item_t item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload register needs no reset.
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item_in;
		end
	end

	assign slot.valid = valid_s1;
	assign slot.item  = item_s1;

endmodule
`default_nettype wire

FILE: hdl/stfb_timers.sv
// Timer state of the soft timer bank and its update for one item.
`default_nettype none
module stfb_timers (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           advance,
	input  stfb_pkg::item_t     item,
	input  stfb_pkg::cfg_t      cfg,
	output stfb_pkg::result_t   result
);

	logic [3:0]  prescale_q, prescale_n;
	logic [15:0] ms_count_q, ms_count_n;
	logic        ms_flag_q, ms_flag_n;
	logic [16:0] memory_count_q, memory_count_n;
	logic        memory_flag_q, memory_flag_n;
	logic [30:0] delay_q, delay_n;
	logic [5:0]  period_q, period_n;
	logic        period_flag_q, period_flag_n;
	logic        first_tick_q, first_tick_n;

	always_comb begin
		logic [3:0] prescale_inc;
		logic [5:0] period_dec;

		prescale_n     = prescale_q;
		ms_count_n     = ms_count_q;
		ms_flag_n      = ms_flag_q;
		memory_count_n = memory_count_q;
		memory_flag_n  = memory_flag_q;
		delay_n        = delay_q;
		period_n       = period_q;
		period_flag_n  = period_flag_q;
		first_tick_n   = first_tick_q;
		prescale_inc   = prescale_q + 4'd1;
		period_dec     = (period_q != '0) ? period_q - 6'd1 : period_q;

		case (item.func)
			stfb_pkg::FUNC_TICK: begin
				if (first_tick_q) begin
					first_tick_n = 1'b0;
					ms_flag_n    = 1'b0;
				end
				if (delay_q != '0) begin
					delay_n = delay_q - 31'd1;
				end
				if (prescale_inc >= cfg.ms_prescale) begin
					prescale_n = '0;
					if (ms_count_q != '0) begin
						ms_count_n = ms_count_q - 16'd1;
						if (ms_count_q == 16'd1) begin
							ms_flag_n = 1'b1;
						end
					end
				end else begin
					prescale_n = prescale_inc;
				end
				if (period_dec == '0) begin
					period_n      = cfg.periodic_reload;
					period_flag_n = 1'b1;
				end else begin
					period_n = period_dec;
				end
				if (memory_count_q != '0) begin
					memory_count_n = memory_count_q - 17'd1;
					if (memory_count_q == 17'd1) begin
						memory_flag_n = 1'b1;
					end
				end
			end
			stfb_pkg::FUNC_ARM_MS: begin
				if (item.ms_value != '0) begin
					ms_count_n = item.ms_value;
					ms_flag_n  = 1'b0;
					prescale_n = '0;
				end else begin
					ms_flag_n = 1'b1;
				end
			end
			stfb_pkg::FUNC_ARM_SHORT: begin
				memory_count_n = cfg.short_memory_ticks;
				memory_flag_n  = 1'b0;
			end
			stfb_pkg::FUNC_ARM_LONG: begin
				memory_count_n = cfg.long_memory_ticks;
				memory_flag_n  = 1'b0;
			end
			stfb_pkg::FUNC_LOAD_DELAY: begin
				delay_n = item.delay_value;
			end
			stfb_pkg::FUNC_WRITE_MS_FLAG: begin
				ms_flag_n = item.flag_value;
			end
			stfb_pkg::FUNC_CLEAR_PERIOD: begin
				period_flag_n = 1'b0;
			end
			stfb_pkg::FUNC_SET_PERIOD: begin
				period_flag_n = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q     <= '0;
			ms_count_q     <= '0;
			ms_flag_q      <= 1'b0;
			memory_count_q <= '0;
			memory_flag_q  <= 1'b0;
			delay_q        <= '0;
			period_q       <= '0;
			period_flag_q  <= 1'b1;
			first_tick_q   <= 1'b1;
		end else if (advance) begin
			prescale_q     <= prescale_n;
			ms_count_q     <= ms_count_n;
			ms_flag_q      <= ms_flag_n;
			memory_count_q <= memory_count_n;
			memory_flag_q  <= memory_flag_n;
			delay_q        <= delay_n;
			period_q       <= period_n;
			period_flag_q  <= period_flag_n;
			first_tick_q   <= first_tick_n;
		end
	end

	// The result reports the state as it stands after this item.
	assign result.ms_done        = ms_flag_n;
	assign result.memory_expired = memory_flag_n;
	assign result.delay_left     = delay_n;
	assign result.periodic_flag  = period_flag_n;

endmodule
`default_nettype wire

FILE: hdl/stfb_out_stage.sv
// Result register stage of the soft timer bank.
`default_nettype none
module stfb_out_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           advance,
	input  wire logic           out_stall,
	input  stfb_pkg::result_t   result_in,
	output logic                out_valid,
	output stfb_pkg::result_t   result_out
);

	logic              valid_s2;
	stfb_pkg::result_t result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_in;
		end
	end

	assign out_valid  = valid_s2;
	assign result_out = result_s2;

endmodule
`default_nettype wire

FILE: hdl/stfb_checker.sv
// Port level checker for the soft timer bank, bound to the top level.
`default_nettype none
`include "tick_driven_soft_timer_bank_macros.svh"
module stfb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        ms_done,
	input wire logic        memory_expired,
	input wire logic [30:0] delay_left,
	input wire logic        periodic_flag
);

	// A stalled result stays offered.
	`STFB_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid)

	// A stalled result keeps its payload.
	`STFB_ASSERT_MSG(a_out_stable, out_valid && out_stall |=> $stable(delay_left) && $stable(ms_done) && $stable(memory_expired) && $stable(periodic_flag), "stalled result changed")

	// The input side only stalls while the result is offered and stalled.
	`STFB_ASSERT_MSG(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without backpressure")

	// A result after an empty output comes from an item that has passed through the input register.
	`STFB_ASSERT_MSG(a_latency, $rose(out_valid) |-> $past(in_valid && !in_stall, 2), "result without an accepted item")

endmodule

bind tick_driven_soft_timer_bank stfb_checker u_stfb_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.ms_done        (ms_done),
	.memory_expired (memory_expired),
	.delay_left     (delay_left),
	.periodic_flag  (periodic_flag)
);
`default_nettype wire
